@@ hdl/spr_pkg.sv @@
// Shared types, register offsets and codes for the serial port register model.
// No dependencies; used by spr_step and serial_port_register_model.
package spr_pkg;

	// Configuration
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 5;

	localparam logic [CfgIdxW-1:0] CFG_VARIANT   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_TX_OFFSET = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_RX_OFFSET = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_XCHG      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_DMA       = 3'd4;

	localparam logic [1:0] VAR_CLASSIC  = 2'd0;
	localparam logic [1:0] VAR_GATED    = 2'd1;
	localparam logic [1:0] VAR_ENHANCED = 2'd2;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_LINE  = 2'd2;

	// Register offsets
	localparam logic [4:0] OFF_STATUS   = 5'h0A;
	localparam logic [4:0] OFF_ERXBUF   = 5'h0C;
	localparam logic [4:0] OFF_IE       = 5'h1A;
	localparam logic [4:0] OFF_IFG      = 5'h1C;
	localparam logic [4:0] OFF_IV       = 5'h1E;
	localparam logic [4:0] OFF_CTL      = 5'h01;
	localparam logic [4:0] OFF_BAUD_LO  = 5'h02;
	localparam logic [4:0] OFF_BAUD_HI  = 5'h03;
	localparam logic [4:0] OFF_RX_DFLT  = 5'h06;

	localparam logic [4:0] TX_OFFSET_RST = 5'd7;

	localparam logic [15:0] FLAG_TX = 16'h0002;
	localparam logic [15:0] FLAG_RX = 16'h0001;

	localparam logic [15:0] IV_RX     = 16'h0002;
	localparam logic [15:0] IV_TX     = 16'h0004;
	localparam logic [15:0] TX_EMPTY  = 16'h0001;

	typedef struct packed {
		logic [1:0] variant;
		logic [4:0] send_off;
		logic [4:0] recv_off;
		logic       xchg;
		logic       dma;
	} cfg_t;

	typedef struct packed {
		logic [15:0] enh_flags;
		logic [15:0] enh_enables;
		logic        tx_flag;
		logic        rx_flag;
		logic [7:0]  rx_buffer;
		logic        soft_reset;
		logic [7:0]  baud_low;
		logic [7:0]  baud_high;
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  offset;
		logic [15:0] write_data;
		logic        reply_valid;
		logic [7:0]  reply_byte;
		logic [7:0]  line_byte;
		logic        ext_tx_enable;
		logic        ext_rx_enable;
	} word_in_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        exchange_request;
		logic        dma_request;
		logic        shared_irq;
		logic        tx_irq;
		logic        rx_irq;
	} word_out_t;

endpackage

@@ hdl/serial_port_register_model.sv @@
// Top level of the serial port register model: configuration, register state, result register.
// Depends on spr_pkg and spr_step.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one word per access: a bus read, a bus
//    write, or a byte received from the line (kind). Every word gives exactly one
//    result word on the output channel (out_valid/out_ready).
//  - A word is decoded against the current register state in the cycle it is accepted;
//    the register state updates at that edge and the result lands in the result
//    register, from which it drives the output channel with out_valid.
//  - Throughput is one word per cycle: in_ready is high whenever the result register
//    is empty or its word is taken in the same cycle, so back-to-back words stream
//    with no gap. The combinational decode feeding the state registers sets this figure.
//  - When the receiver stalls (out_ready low with a word held), in_ready drops and the
//    held result stays stable until taken.
//  - Configuration (cfg_write, cfg_index, cfg_data) writes at any edge with cfg_write
//    high; indexes beyond the register list are ignored. Change it only while idle.
//  - Reset (arst_n low, asynchronous) empties the result register, restores the
//    configuration defaults (transmit offset 7) and the register state: transmit and
//    receive flags set, soft reset set, enhanced flags 0x0002, all else zero.
module serial_port_register_model (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [spr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [spr_pkg::CfgDataW-1:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [4:0]  offset,
	input  logic [15:0] write_data,
	input  logic        reply_valid,
	input  logic [7:0]  reply_byte,
	input  logic [7:0]  line_byte,
	input  logic        ext_tx_enable,
	input  logic        ext_rx_enable,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic        send_valid,
	output logic [7:0]  send_byte,
	output logic        exchange_request,
	output logic        dma_request,
	output logic        shared_irq,
	output logic        tx_irq,
	output logic        rx_irq
);

	spr_pkg::cfg_t      cfg_q;
	spr_pkg::state_t    state_q;
	spr_pkg::state_t    state_nxt;
	spr_pkg::word_in_t  win;
	spr_pkg::word_out_t wout;
	spr_pkg::word_out_t res_s1;
	logic               valid_s1;
	logic               accept;

	// result register frees up when empty or drained this cycle
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variant  <= spr_pkg::VAR_CLASSIC;
			cfg_q.send_off <= spr_pkg::TX_OFFSET_RST;
			cfg_q.recv_off <= 5'd0;
			cfg_q.xchg     <= 1'b0;
			cfg_q.dma      <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				spr_pkg::CFG_VARIANT:   cfg_q.variant  <= cfg_data[1:0];
				spr_pkg::CFG_TX_OFFSET: cfg_q.send_off <= cfg_data[4:0];
				spr_pkg::CFG_RX_OFFSET: cfg_q.recv_off <= cfg_data[4:0];
				spr_pkg::CFG_XCHG:      cfg_q.xchg     <= cfg_data[0];
				spr_pkg::CFG_DMA:       cfg_q.dma      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign win.kind          = kind;
	assign win.offset        = offset;
	assign win.write_data    = write_data;
	assign win.reply_valid   = reply_valid;
	assign win.reply_byte    = reply_byte;
	assign win.line_byte     = line_byte;
	assign win.ext_tx_enable = ext_tx_enable;
	assign win.ext_rx_enable = ext_rx_enable;

	spr_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.win  (win),
		.nxt  (state_nxt),
		.wout (wout)
	);

	// peripheral register state, updated once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.enh_flags   <= spr_pkg::FLAG_TX;
			state_q.enh_enables <= 16'd0;
			state_q.tx_flag     <= 1'b1;
			state_q.rx_flag     <= 1'b1;
			state_q.rx_buffer   <= 8'd0;
			state_q.soft_reset  <= 1'b1;
			state_q.baud_low    <= 8'd0;
			state_q.baud_high   <= 8'd0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result register: valid under reset, payload load-only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= wout;
		end
	end

	assign out_valid        = valid_s1;
	assign read_data        = res_s1.read_data;
	assign send_valid       = res_s1.send_valid;
	assign send_byte        = res_s1.send_byte;
	assign exchange_request = res_s1.exchange_request;
	assign dma_request      = res_s1.dma_request;
	assign shared_irq       = res_s1.shared_irq;
	assign tx_irq           = res_s1.tx_irq;
	assign rx_irq           = res_s1.rx_irq;

endmodule

@@ hdl/spr_step.sv @@
// Combinational register access: next register state and result word for one input word.
// Depends on spr_pkg.
module spr_step (
	input  spr_pkg::cfg_t      cfg,
	input  spr_pkg::state_t    cur,
	input  spr_pkg::word_in_t  win,
	output spr_pkg::state_t    nxt,
	output spr_pkg::word_out_t wout
);

	logic       enh;
	logic       gated;
	logic       upd;
	logic       done;
	logic       blocked;
	logic       resp;
	logic [4:0] rxoff;
	logic [15:0] pend;

	assign enh   = (cfg.variant == spr_pkg::VAR_ENHANCED);
	assign gated = (cfg.variant == spr_pkg::VAR_GATED);
	assign pend  = cur.enh_flags & cur.enh_enables;

	always_comb begin
		nxt     = cur;
		wout    = '0;
		upd     = 1'b0;
		done    = 1'b0;
		blocked = 1'b0;
		resp    = 1'b0;
		rxoff   = enh ? spr_pkg::OFF_ERXBUF
			: ((cfg.recv_off != 5'd0) ? cfg.recv_off : spr_pkg::OFF_RX_DFLT);

		case (win.kind)
			spr_pkg::KIND_READ: begin
				if (enh) begin
					if (win.offset == spr_pkg::OFF_IFG) begin
						wout.read_data = cur.enh_flags;
						done = 1'b1;
					end else if (win.offset == spr_pkg::OFF_IE) begin
						wout.read_data = cur.enh_enables;
						done = 1'b1;
					end else if (win.offset == spr_pkg::OFF_STATUS) begin
						done = 1'b1;
					end else if (win.offset == spr_pkg::OFF_IV) begin
						done = 1'b1;
						// receive wins; the reported flag is cleared
						if ((pend & spr_pkg::FLAG_RX) != '0) begin
							nxt.enh_flags  = cur.enh_flags & ~spr_pkg::FLAG_RX;
							wout.read_data = spr_pkg::IV_RX;
						end else if ((pend & spr_pkg::FLAG_TX) != '0) begin
							nxt.enh_flags  = cur.enh_flags & ~spr_pkg::FLAG_TX;
							wout.read_data = spr_pkg::IV_TX;
						end
					end
				end else if (win.offset == spr_pkg::OFF_CTL && !gated) begin
					wout.read_data = spr_pkg::TX_EMPTY;
					done = 1'b1;
				end
				if (!done && win.offset == rxoff) begin
					if (enh) nxt.enh_flags = cur.enh_flags & ~spr_pkg::FLAG_RX;
					else nxt.rx_flag = 1'b0;
					upd = 1'b1;
					wout.read_data = {8'd0, cur.rx_buffer};
				end
			end
			spr_pkg::KIND_WRITE: begin
				if (enh) begin
					if (win.offset == spr_pkg::OFF_IE) begin
						nxt.enh_enables = win.write_data;
						done = 1'b1;
					end else if (win.offset == spr_pkg::OFF_IFG) begin
						// a flag write always leaves the transmit flag set
						nxt.enh_flags = win.write_data | spr_pkg::FLAG_TX;
						done = 1'b1;
					end
				end
				if (!done && gated) begin
					if (win.offset == spr_pkg::OFF_CTL) begin
						nxt.soft_reset = win.write_data[0];
						if (cur.soft_reset && !win.write_data[0]) begin
							nxt.tx_flag = 1'b1;
							nxt.rx_flag = 1'b0;
							upd = 1'b1;
						end
					end
					if (win.offset == spr_pkg::OFF_BAUD_LO) nxt.baud_low = win.write_data[7:0];
					if (win.offset == spr_pkg::OFF_BAUD_HI) nxt.baud_high = win.write_data[7:0];
				end
				if (!done && win.offset == cfg.send_off) begin
					// gating sees the control and baud values written by this same word
					blocked = gated && !cfg.xchg &&
						(nxt.soft_reset || (nxt.baud_low == 8'd0 && nxt.baud_high == 8'd0));
					wout.send_byte = win.write_data[7:0];
					if (cfg.xchg) begin
						wout.exchange_request = 1'b1;
						if (win.reply_valid) begin
							nxt.rx_buffer = win.reply_byte;
							resp = 1'b1;
						end
					end
					wout.send_valid = !blocked;
					if (enh) begin
						nxt.enh_flags = nxt.enh_flags | spr_pkg::FLAG_TX |
							(resp ? spr_pkg::FLAG_RX : 16'd0);
					end else begin
						nxt.tx_flag = 1'b1;
						if (resp || !cfg.xchg) nxt.rx_flag = 1'b1;
					end
					upd = 1'b1;
				end
			end
			spr_pkg::KIND_LINE: begin
				nxt.rx_buffer = win.line_byte;
				if (cfg.dma) begin
					// DMA takes the byte at once, so the receive flag ends cleared
					wout.dma_request = 1'b1;
					if (enh) nxt.enh_flags = cur.enh_flags & ~spr_pkg::FLAG_RX;
					else nxt.rx_flag = 1'b0;
				end else begin
					if (enh) nxt.enh_flags = cur.enh_flags | spr_pkg::FLAG_RX;
					else nxt.rx_flag = 1'b1;
				end
				upd = 1'b1;
			end
			default: begin
			end
		endcase

		wout.shared_irq = enh && ((nxt.enh_flags & nxt.enh_enables) != '0);
		wout.tx_irq     = !enh && upd && nxt.tx_flag && win.ext_tx_enable;
		wout.rx_irq     = !enh && upd && nxt.rx_flag && win.ext_rx_enable;
	end

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for serial_port_register_model: register access, line bytes, flag/IRQ behavior.
// Depends on spr_pkg (types, offsets, codes) and the RTL top level; holds its own shadow model.
`timescale 1ns / 1ps

// Shadow of the register file: predicts each result word and checks the block's output.
class serial_port_shadow;
	spr_pkg::cfg_t      cfg;
	spr_pkg::state_t    st;
	spr_pkg::word_out_t pending_results[$];
	int unsigned        errors;

	function new();
		cfg = '{variant: spr_pkg::VAR_CLASSIC, send_off: spr_pkg::TX_OFFSET_RST,
			recv_off: 5'd0, xchg: 1'b0, dma: 1'b0};
		st = '{enh_flags: spr_pkg::FLAG_TX, enh_enables: 16'h0000, tx_flag: 1'b1,
			rx_flag: 1'b1, rx_buffer: 8'h00, soft_reset: 1'b1, baud_low: 8'h00,
			baud_high: 8'h00};
		errors = 0;
	endfunction

	function void write_reg(logic [spr_pkg::CfgIdxW-1:0] idx,
		logic [spr_pkg::CfgDataW-1:0] data);
		case (idx)
			spr_pkg::CFG_VARIANT:   cfg.variant  = data[1:0];
			spr_pkg::CFG_TX_OFFSET: cfg.send_off = data;
			spr_pkg::CFG_RX_OFFSET: cfg.recv_off = data;
			spr_pkg::CFG_XCHG:      cfg.xchg     = data[0];
			spr_pkg::CFG_DMA:       cfg.dma      = data[0];
			default: ;
		endcase
	endfunction

	// Work out the result of one accepted word and update the shadow state.
	function void note_access(spr_pkg::word_in_t w);
		spr_pkg::word_out_t r;
		logic       enh, gated, upd, done, blocked, resp;
		logic [4:0] rx_sel;
		logic [15:0] pend;
		r = '0;
		upd = 1'b0;
		done = 1'b0;
		blocked = 1'b0;
		resp = 1'b0;
		enh = (cfg.variant == spr_pkg::VAR_ENHANCED);
		gated = (cfg.variant == spr_pkg::VAR_GATED);
		case (w.kind)
			spr_pkg::KIND_READ: begin
				if (enh) begin
					case (w.offset)
						spr_pkg::OFF_IFG: begin
							r.read_data = st.enh_flags;
							done = 1'b1;
						end
						spr_pkg::OFF_IE: begin
							r.read_data = st.enh_enables;
							done = 1'b1;
						end
						spr_pkg::OFF_STATUS: begin
							done = 1'b1;
						end
						spr_pkg::OFF_IV: begin
							// receive wins; the reported flag is cleared
							done = 1'b1;
							pend = st.enh_flags & st.enh_enables;
							if (|(pend & spr_pkg::FLAG_RX)) begin
								st.enh_flags &= ~spr_pkg::FLAG_RX;
								r.read_data = spr_pkg::IV_RX;
							end else if (|(pend & spr_pkg::FLAG_TX)) begin
								st.enh_flags &= ~spr_pkg::FLAG_TX;
								r.read_data = spr_pkg::IV_TX;
							end
						end
						default: ;
					endcase
				end else if (w.offset == spr_pkg::OFF_CTL && !gated) begin
					r.read_data = spr_pkg::TX_EMPTY;
					done = 1'b1;
				end
				if (!done) begin
					rx_sel = enh ? spr_pkg::OFF_ERXBUF :
						((cfg.recv_off != 5'd0) ? cfg.recv_off : spr_pkg::OFF_RX_DFLT);
					if (w.offset == rx_sel) begin
						if (enh)
							st.enh_flags &= ~spr_pkg::FLAG_RX;
						else
							st.rx_flag = 1'b0;
						upd = 1'b1;
						r.read_data = {8'h00, st.rx_buffer};
					end
				end
			end
			spr_pkg::KIND_WRITE: begin
				if (enh) begin
					if (w.offset == spr_pkg::OFF_IE) begin
						st.enh_enables = w.write_data;
						done = 1'b1;
					end else if (w.offset == spr_pkg::OFF_IFG) begin
						st.enh_flags = w.write_data | spr_pkg::FLAG_TX;
						done = 1'b1;
					end
				end
				if (!done && gated) begin
					if (w.offset == spr_pkg::OFF_CTL) begin
						if (st.soft_reset && !w.write_data[0]) begin
							st.tx_flag = 1'b1;
							st.rx_flag = 1'b0;
							upd = 1'b1;
						end
						st.soft_reset = w.write_data[0];
					end
					if (w.offset == spr_pkg::OFF_BAUD_LO)
						st.baud_low = w.write_data[7:0];
					if (w.offset == spr_pkg::OFF_BAUD_HI)
						st.baud_high = w.write_data[7:0];
				end
				if (!done && w.offset == cfg.send_off) begin
					blocked = gated && !cfg.xchg &&
						(st.soft_reset || (st.baud_low == 8'h00 && st.baud_high == 8'h00));
					r.send_byte = w.write_data[7:0];
					if (cfg.xchg) begin
						r.exchange_request = 1'b1;
						if (w.reply_valid) begin
							st.rx_buffer = w.reply_byte;
							resp = 1'b1;
						end
					end
					r.send_valid = !blocked;
					if (enh) begin
						st.enh_flags |= spr_pkg::FLAG_TX;
						if (resp)
							st.enh_flags |= spr_pkg::FLAG_RX;
					end else begin
						st.tx_flag = 1'b1;
						if (resp || !cfg.xchg)
							st.rx_flag = 1'b1;
					end
					upd = 1'b1;
				end
			end
			spr_pkg::KIND_LINE: begin
				st.rx_buffer = w.line_byte;
				if (enh)
					st.enh_flags |= spr_pkg::FLAG_RX;
				else
					st.rx_flag = 1'b1;
				if (cfg.dma) begin
					r.dma_request = 1'b1;
					if (enh)
						st.enh_flags &= ~spr_pkg::FLAG_RX;
					else
						st.rx_flag = 1'b0;
				end
				upd = 1'b1;
			end
			default: ;
		endcase
		r.shared_irq = enh && (|(st.enh_flags & st.enh_enables));
		if (!enh && upd) begin
			r.tx_irq = st.tx_flag && w.ext_tx_enable;
			r.rx_irq = st.rx_flag && w.ext_rx_enable;
		end
		pending_results.push_back(r);
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(spr_pkg::word_out_t got);
		spr_pkg::word_out_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("read_data", want.read_data, got.read_data);
		compare_field("send_valid", 16'(want.send_valid), 16'(got.send_valid));
		compare_field("send_byte", 16'(want.send_byte), 16'(got.send_byte));
		compare_field("exchange_request", 16'(want.exchange_request),
			16'(got.exchange_request));
		compare_field("dma_request", 16'(want.dma_request), 16'(got.dma_request));
		compare_field("shared_irq", 16'(want.shared_irq), 16'(got.shared_irq));
		compare_field("tx_irq", 16'(want.tx_irq), 16'(got.tx_irq));
		compare_field("rx_irq", 16'(want.rx_irq), 16'(got.rx_irq));
	endfunction
endclass

module tb_top;

	// Codes the package leaves unnamed: the spare variant (acts as classic) and the spare kind.
	localparam logic [1:0] VAR_SPARE  = 2'd3;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int unsigned PHASE_WORDS    = 142;
	localparam int unsigned LONG_HOLD      = 300;  // receiver hold-off, in cycles
	localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no handshake at all
	localparam int unsigned TAIL_CYCLES    = 4;    // result register plus margin

	logic clk = 1'b0;
	logic arst_n;

	logic                         cfg_write;
	logic [spr_pkg::CfgIdxW-1:0]  cfg_index;
	logic [spr_pkg::CfgDataW-1:0] cfg_data;

	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [4:0]  offset;
	logic [15:0] write_data;
	logic        reply_valid;
	logic [7:0]  reply_byte;
	logic [7:0]  line_byte;
	logic        ext_tx_enable;
	logic        ext_rx_enable;

	logic        out_valid;
	logic        out_ready;
	logic [15:0] read_data;
	logic        send_valid;
	logic [7:0]  send_byte;
	logic        exchange_request;
	logic        dma_request;
	logic        shared_irq;
	logic        tx_irq;
	logic        rx_irq;

	// Handshakes between the sender and the receiver processes.
	bit quiet = 1'b0;          // last phase: nobody idles
	bit hold_off_req = 1'b0;   // ask the receiver for one long stall

	int unsigned idle_cycles = 0;

	serial_port_shadow model = new();

	always #5 clk = ~clk;

	serial_port_register_model i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.offset           (offset),
		.write_data       (write_data),
		.reply_valid      (reply_valid),
		.reply_byte       (reply_byte),
		.line_byte        (line_byte),
		.ext_tx_enable    (ext_tx_enable),
		.ext_rx_enable    (ext_rx_enable),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.read_data        (read_data),
		.send_valid       (send_valid),
		.send_byte        (send_byte),
		.exchange_request (exchange_request),
		.dma_request      (dma_request),
		.shared_irq       (shared_irq),
		.tx_irq           (tx_irq),
		.rx_irq           (rx_irq)
	);

	// Pack one input word from its fields.
	function automatic spr_pkg::word_in_t access(logic [1:0] k, logic [4:0] o,
		logic [15:0] d, logic rv, logic [7:0] rb, logic [7:0] lb, logic et, logic er);
		spr_pkg::word_in_t w;
		w = '{kind: k, offset: o, write_data: d, reply_valid: rv, reply_byte: rb,
			line_byte: lb, ext_tx_enable: et, ext_rx_enable: er};
		return w;
	endfunction

	// Offer one word and hold it until the block takes it. Called at a rising edge.
	// Valid stays high on return; the caller lowers it only when it idles.
	task automatic send_word(spr_pkg::word_in_t w);
		in_valid      <= 1'b1;
		kind          <= w.kind;
		offset        <= w.offset;
		write_data    <= w.write_data;
		reply_valid   <= w.reply_valid;
		reply_byte    <= w.reply_byte;
		line_byte     <= w.line_byte;
		ext_tx_enable <= w.ext_tx_enable;
		ext_rx_enable <= w.ext_rx_enable;
		// values read right at the edge are the ones the block sampled there
		do @(posedge clk); while (!in_ready);
		model.note_access(w);
	endtask

	// Stop offering and wait for every predicted result to come back.
	// Always waits on a clock edge first, so valid is never lowered and raised in one step.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (model.pending_results.size() != 0);
	endtask

	task automatic poke_cfg(logic [spr_pkg::CfgIdxW-1:0] idx,
		logic [spr_pkg::CfgDataW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		model.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Rewrite the whole register set; only called while the block is idle.
	task automatic set_mode(logic [1:0] v, logic [4:0] txo, logic [4:0] rxo, logic x, logic d);
		poke_cfg(spr_pkg::CFG_VARIANT, {3'b000, v});
		poke_cfg(spr_pkg::CFG_TX_OFFSET, txo);
		poke_cfg(spr_pkg::CFG_RX_OFFSET, rxo);
		poke_cfg(spr_pkg::CFG_XCHG, {4'b0000, x});
		poke_cfg(spr_pkg::CFG_DMA, {4'b0000, d});
		cfg_write <= 1'b0;
	endtask

	// One random phase under a fixed register setting.
	// Offsets lean toward the mapped registers so the flag logic gets exercised;
	// the rest is random noise across the whole offset space.
	task automatic run_phase(logic [1:0] v, logic [4:0] txo, logic [4:0] rxo, logic x,
		logic d, bit with_hold, bit with_pause);
		spr_pkg::word_in_t w;
		int unsigned       pick;
		set_mode(v, txo, rxo, x, d);
		for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
			// sender gaps; none while the receiver is being held off
			if (!quiet && !hold_off_req && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			if (with_hold && i == PHASE_WORDS / 4)
				hold_off_req = 1'b1;
			if (with_pause && i == PHASE_WORDS / 2)
				drain();

			pick = $urandom_range(0, 99);
			if (pick < 40)
				w.kind = spr_pkg::KIND_WRITE;
			else if (pick < 75)
				w.kind = spr_pkg::KIND_READ;
			else if (pick < 95)
				w.kind = spr_pkg::KIND_LINE;
			else
				w.kind = KIND_SPARE;

			case ($urandom_range(0, 15))
				0, 1:    w.offset = model.cfg.send_off;
				2:       w.offset = (model.cfg.recv_off != 5'd0) ? model.cfg.recv_off
				                                                 : spr_pkg::OFF_RX_DFLT;
				3:       w.offset = spr_pkg::OFF_ERXBUF;
				4:       w.offset = spr_pkg::OFF_IE;
				5:       w.offset = spr_pkg::OFF_IFG;
				6:       w.offset = spr_pkg::OFF_IV;
				7:       w.offset = spr_pkg::OFF_STATUS;
				8:       w.offset = spr_pkg::OFF_CTL;
				9:       w.offset = spr_pkg::OFF_BAUD_LO;
				10:      w.offset = spr_pkg::OFF_BAUD_HI;
				default: w.offset = 5'($urandom_range(0, 31));
			endcase

			// small values hit zero baud bytes and clear the soft reset bit
			if ($urandom_range(0, 3) == 0)
				w.write_data = 16'($urandom_range(0, 3));
			else
				w.write_data = 16'($urandom);
			w.reply_valid   = 1'($urandom);
			w.reply_byte    = 8'($urandom);
			w.line_byte     = 8'($urandom);
			w.ext_tx_enable = 1'($urandom);
			w.ext_rx_enable = 1'($urandom);
			send_word(w);
		end
		drain();
	endtask

	// Receiver: random ready/stall bursts, one long hold-off on request,
	// and steady ready in the closing phase.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// Result monitor: every word taken on the output side is checked in order.
	always @(posedge clk) begin
		spr_pkg::word_out_t got;
		if (arst_n && out_valid && out_ready) begin
			got.read_data        = read_data;
			got.send_valid       = send_valid;
			got.send_byte        = send_byte;
			got.exchange_request = exchange_request;
			got.dma_request      = dma_request;
			got.shared_irq       = shared_irq;
			got.tx_irq           = tx_irq;
			got.rx_irq           = rx_irq;
			model.check_result(got);
		end
	end

	// Watchdog: too long without any handshake means the block is stuck.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_write     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		kind          <= spr_pkg::KIND_READ;
		offset        <= '0;
		write_data    <= '0;
		reply_valid   <= 1'b0;
		reply_byte    <= '0;
		line_byte     <= '0;
		ext_tx_enable <= 1'b0;
		ext_rx_enable <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: classic variant straight out of reset.
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_CTL, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		// receive buffer read clears the receive flag; enables at max
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_RX_DFLT, 16'hFFFF, 1'b1, 8'hFF,
			8'hFF, 1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_READ, 5'd0, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_READ, 5'd31, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::TX_OFFSET_RST, 16'hFFFF, 1'b1, 8'hFF,
			8'h00, 1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::TX_OFFSET_RST, 16'h0000, 1'b0, 8'h00,
			8'h00, 1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_LINE, 5'd0, 16'h0000, 1'b0, 8'h00, 8'hFF, 1'b0, 1'b1));
		send_word(access(spr_pkg::KIND_LINE, 5'd31, 16'hFFFF, 1'b1, 8'hFF, 8'h00, 1'b1, 1'b0));
		// unmapped write is ignored
		send_word(access(spr_pkg::KIND_WRITE, 5'd31, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1'b1,
			1'b1));
		// spare kind changes nothing
		send_word(access(KIND_SPARE, 5'd31, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1));
		drain();

		// Directed: enhanced variant with a partner attached; vector priority and clears.
		set_mode(spr_pkg::VAR_ENHANCED, spr_pkg::TX_OFFSET_RST, 5'd0, 1'b1, 1'b0);
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::OFF_IE, 16'hFFFF, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_IV, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_IV, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_LINE, 5'd0, 16'h0000, 1'b0, 8'h00, 8'hA5, 1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_IV, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		// flag write keeps the transmit flag set
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::OFF_IFG, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_IFG, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b0, 1'b0));
		// exchange with a reply loads the buffer, then one without leaves it alone
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::TX_OFFSET_RST, 16'h005A, 1'b1, 8'hC3,
			8'h00, 1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_ERXBUF, 16'h0000, 1'b0, 8'h00,
			8'h00, 1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::TX_OFFSET_RST, 16'h0077, 1'b0, 8'h99,
			8'h00, 1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_READ, spr_pkg::OFF_STATUS, 16'h0000, 1'b0, 8'h00,
			8'h00, 1'b0, 1'b0));
		drain();

		// Directed: gated variant, no partner, DMA on; console blocked until set up.
		set_mode(spr_pkg::VAR_GATED, spr_pkg::TX_OFFSET_RST, 5'd0, 1'b0, 1'b1);
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::TX_OFFSET_RST, 16'h0011, 1'b0, 8'h00,
			8'h00, 1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::OFF_CTL, 16'h0000, 1'b0, 8'h00, 8'h00,
			1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::OFF_BAUD_LO, 16'h00FF, 1'b0, 8'h00,
			8'h00, 1'b0, 1'b0));
		send_word(access(spr_pkg::KIND_WRITE, spr_pkg::TX_OFFSET_RST, 16'h0022, 1'b0, 8'h00,
			8'h00, 1'b1, 1'b1));
		send_word(access(spr_pkg::KIND_LINE, 5'd0, 16'h0000, 1'b0, 8'h00, 8'h3C, 1'b1, 1'b1));
		drain();

		// Random phases; settings sweep the variants and the offset extremes.
		run_phase(spr_pkg::VAR_GATED, spr_pkg::TX_OFFSET_RST, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		run_phase(spr_pkg::VAR_ENHANCED, spr_pkg::TX_OFFSET_RST, 5'd0, 1'b1, 1'b0, 1'b0,
			1'b0);
		run_phase(spr_pkg::VAR_CLASSIC, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0);
		run_phase(spr_pkg::VAR_GATED, 5'd0, spr_pkg::OFF_RX_DFLT, 1'b0, 1'b1, 1'b0, 1'b0);
		run_phase(spr_pkg::VAR_ENHANCED, spr_pkg::OFF_IV, spr_pkg::OFF_ERXBUF, 1'b0, 1'b1,
			1'b0, 1'b1);
		run_phase(VAR_SPARE, spr_pkg::OFF_CTL, spr_pkg::OFF_CTL, 1'b1, 1'b0, 1'b0, 1'b0);
		run_phase(spr_pkg::VAR_GATED, spr_pkg::OFF_CTL, spr_pkg::OFF_BAUD_LO, 1'b1, 1'b0,
			1'b0, 1'b0);
		run_phase(spr_pkg::VAR_ENHANCED, spr_pkg::OFF_IE, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		quiet = 1'b1;
		run_phase(spr_pkg::VAR_CLASSIC, spr_pkg::TX_OFFSET_RST, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);

		// everything is back; wait out the tail margin for stray output
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.errors == 0 && model.pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
